[sv/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// lgs_pkg: shared definitions for the Life generation stencil unit
// Register indexes, fixed field widths and the flag group passed from the
// raster counter to the evaluation stage.
// ----------------------------------------------------------------------------
package lgs_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

  // Geometry after reset, before clamping to the build limits
  localparam int unsigned CFG_DIM_RST = 1024;

  // Width of the reported row/column fields
  localparam int unsigned OUT_POS_W = 10;

  // One column of the 3-high stripe: bit 0 top, bit 1 middle, bit 2 bottom
  localparam int unsigned COL_H = 3;

  // Per-cell flags produced by the raster counter
  typedef struct packed {
    logic emit;  // interior cell (r-1, c-1) completes on this cell
    logic last;  // that interior cell is the final one of the grid
  } pos_flags_t;

endpackage

[sv/lgs_ram.sv]
// ----------------------------------------------------------------------------
// lgs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// The read register holds its value while no read is issued.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/lgs_raster.sv]
// ----------------------------------------------------------------------------
// lgs_raster: grid geometry registers and raster position counter
// Holds the clamped last row/column index, tracks the position of the next
// cell to arrive and flags cells that complete an interior neighbourhood.
// ----------------------------------------------------------------------------
module lgs_raster import lgs_pkg::*; #(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  // one cell accepted
  input  logic                        step_i,
  // position of the next cell to arrive
  output logic [$clog2(MAX_ROWS)-1:0] row_o,
  output logic [$clog2(MAX_COLS)-1:0] col_o,
  output pos_flags_t                  flags_o
);

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);

  // Last valid index for a programmed dimension: below 3 acts as 3,
  // above the build limit acts as the limit.
  function automatic int unsigned dim_last(int unsigned v, int unsigned maxv);
    int unsigned res;
    if (v < 3) begin
      res = 2;
    end else if (v > maxv) begin
      res = maxv - 1;
    end else begin
      res = v - 1;
    end
    return res;
  endfunction

  localparam logic [RW-1:0] ROWS_M1_RST = RW'(dim_last(CFG_DIM_RST, MAX_ROWS));
  localparam logic [CW-1:0] COLS_M1_RST = CW'(dim_last(CFG_DIM_RST, MAX_COLS));

  logic [RW-1:0] rows_m1_q, rows_m1_d;
  logic [CW-1:0] cols_m1_q, cols_m1_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic          col_wrap;
  logic          row_wrap;

  assign col_wrap = (col_q == cols_m1_q);
  assign row_wrap = (row_q == rows_m1_q);

  // Geometry writes and raster stepping; a known register write restarts the frame
  always_comb begin
    rows_m1_d = rows_m1_q;
    cols_m1_d = cols_m1_q;
    row_d     = row_q;
    col_d     = col_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRID_ROWS: begin
          rows_m1_d = RW'(dim_last(32'(cfg_data_i), MAX_ROWS));
          row_d     = '0;
          col_d     = '0;
        end
        REG_GRID_COLS: begin
          cols_m1_d = CW'(dim_last(32'(cfg_data_i), MAX_COLS));
          row_d     = '0;
          col_d     = '0;
        end
        default: begin
        end
      endcase
    end else if (step_i) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m1_q <= ROWS_M1_RST;
      cols_m1_q <= COLS_M1_RST;
      row_q     <= '0;
      col_q     <= '0;
    end else begin
      rows_m1_q <= rows_m1_d;
      cols_m1_q <= cols_m1_d;
      row_q     <= row_d;
      col_q     <= col_d;
    end
  end

  assign row_o        = row_q;
  assign col_o        = col_q;
  assign flags_o.emit = (row_q >= RW'(2)) && (col_q >= CW'(2));
  assign flags_o.last = row_wrap && col_wrap;

endmodule

[sv/lgs_window.sv]
// ----------------------------------------------------------------------------
// lgs_window: 3x3 neighbourhood window and B3/S23 rule
// Keeps the two previous columns of the stripe; together with the incoming
// column they give the eight neighbours of the centre cell.
// ----------------------------------------------------------------------------
module lgs_window import lgs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [COL_H-1:0] col_new_i,
  output logic             next_alive_o
);

  logic [COL_H-1:0] centre_q;
  logic [COL_H-1:0] left_q;
  logic [7:0]       nbrs;
  logic [3:0]       total;

  // Shift the stripe one column on every processed cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q <= '0;
      left_q   <= '0;
    end else if (shift_i) begin
      left_q   <= centre_q;
      centre_q <= col_new_i;
    end
  end

  // Neighbour count, centre cell itself excluded
  assign nbrs = {left_q, col_new_i, centre_q[2], centre_q[0]};

  always_comb begin
    total = '0;
    for (int i = 0; i < 8; i++) begin
      total = total + {3'b000, nbrs[i]};
    end
  end

  assign next_alive_o = (total == 4'd3) || (centre_q[1] && (total == 4'd2));

endmodule

[sv/life_generation_stencil_unit.sv]
// ----------------------------------------------------------------------------
// life_generation_stencil_unit: streaming Conway Life generation (B3/S23)
// Cells enter one per transfer on the input channel in raster order, row 0
// first. Once the cell at row r, column c (both at least 2) arrives, the next
// state of interior cell (r-1, c-1) leaves on the output channel with its
// position; border cells produce no result. frame_last marks the final
// interior cell, after which the next cell starts a new frame.
// The configuration channel writes grid_rows (index 0) and grid_cols
// (index 1); a write to either restarts the frame. Write it only while idle.
// A result passes through the evaluation stage register, then the output register.
// Throughput: one cell per cycle unless the receiver stalls, set by the line store
// RAM doing one read (incoming column) and one write-back (stage 1 column) each cycle.
// A stalled receiver holds the output register; input keeps flowing until the
// one-deep evaluation stage also holds a result-bearing cell.
// Reset clears the counters, window and channel state; geometry returns to
// 1024x1024 (clamped to MAX_ROWS/MAX_COLS). The line store is not cleared:
// an entry is always rewritten in the row before it is used.
// ----------------------------------------------------------------------------
module life_generation_stencil_unit import lgs_pkg::*; #(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cell_alive_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_POS_W-1:0]  out_row_o,
  output logic [OUT_POS_W-1:0]  out_col_o,
  output logic                  next_alive_o,
  output logic                  frame_last_o
);

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);

  logic          cfg_we;
  logic          in_xfer;
  logic [RW-1:0] pos_row;
  logic [CW-1:0] pos_col;
  pos_flags_t    pos_flags;

  // evaluation stage
  logic          s1_valid_q, s1_valid_d;
  logic          s1_bot_q;
  logic [RW-1:0] s1_row_q;
  logic [CW-1:0] s1_col_q;
  pos_flags_t    s1_flags_q;
  logic          s1_adv;

  // line store: bit 0 row above, bit 1 two rows above
  logic [1:0]       line_rd;
  logic [COL_H-1:0] col_new;
  logic             rule_alive;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [OUT_POS_W-1:0] out_row_q;
  logic [OUT_POS_W-1:0] out_col_q;
  logic                 next_alive_q;
  logic                 frame_last_q;
  logic                 out_load;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  // Stage 1 moves on unless its result would overwrite an untaken one
  assign s1_adv     = s1_valid_q && (!s1_flags_q.emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = s1_adv && s1_flags_q.emit;

  // Raster position and geometry
  lgs_raster #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (in_xfer),
    .row_o       (pos_row),
    .col_o       (pos_col),
    .flags_o     (pos_flags)
  );

  // Line store: read on transfer, write back shifted column in stage 1
  lgs_ram #(
    .WIDTH (2),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i ({line_rd[0], s1_bot_q}),
    .re_i    (in_xfer),
    .raddr_i (pos_col),
    .rdata_o (line_rd)
  );

  assign col_new = {s1_bot_q, line_rd[0], line_rd[1]};

  lgs_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .shift_i      (s1_adv),
    .col_new_i    (col_new),
    .next_alive_o (rule_alive)
  );

  // Stage 1 capture
  assign s1_valid_d = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_bot_q   <= cell_alive_i;
      s1_row_q   <= pos_row;
      s1_col_q   <= pos_col;
      s1_flags_q <= pos_flags;
    end
  end

  // Output register
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q    <= OUT_POS_W'(s1_row_q - RW'(1));
      out_col_q    <= OUT_POS_W'(s1_col_q - CW'(1));
      next_alive_q <= rule_alive;
      frame_last_q <= s1_flags_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign next_alive_o = next_alive_q;
  assign frame_last_o = frame_last_q;

  // Read and write-back of the line store never hit the same column
  a_ram_no_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s1_adv) |-> (pos_col != s1_col_q))
    else $error("line store read and write address collide");

  // A result is never loaded over one still waiting
  a_out_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // Frame end always lands on an interior cell
  a_last_is_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_flags_q.last) |-> s1_flags_q.emit)
    else $error("frame end flagged on a border cell");

  // A new result only appears from an occupied evaluation stage
  a_out_from_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a cell in stage 1");

endmodule

[tb/tb_life_generation_stencil_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_generation_stencil_unit: self-checking bench for the Life stencil
// Streams grids through the cell channel under random valid/ready gaps and
// checks every reported interior cell against a B3/S23 line-buffer model kept
// in the bench. A directed table comes first: a 3x1024 slice, hand-made 3x3 frames,
// slices of the tallest and widest geometries; then random shapes and contents.
// ----------------------------------------------------------------------------
module tb_life_generation_stencil_unit;
  import lgs_pkg::*;

  localparam int unsigned GRID_MAX_ROWS = 1024;
  localparam int unsigned GRID_MAX_COLS = 1024;
  localparam int          HALF_PERIOD   = 5;
  localparam int          RESET_CYCLES  = 9;
  // results pass the evaluation stage and output register; idle after draining before a write
  localparam int          SETTLE_CYCLES = 4;
  localparam int          TAIL_CYCLES   = 10;
  localparam int          HOLD_AT       = 6;
  localparam int          LONG_HOLD     = 80;
  localparam int          SLICE_CELLS   = 40;
  localparam int          RAND_CELLS    = 260;
  localparam int          RAND_RESULTS  = 48;
  localparam longint      WATCHDOG_NS   = 5_000_000;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic                 next;
    logic                 last;
  } life_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_CELLS, ROW_FRAME} stim_kind_e;

  typedef struct {
    stim_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    int                    ncells;
    logic [8:0]            pattern;  // cells in raster order, bit 0 first
    bit                    typed;
    logic [OUT_POS_W-1:0]  exp_row;
    logic [OUT_POS_W-1:0]  exp_col;
    logic                  exp_next;
    logic                  exp_last;
  } stim_row_t;

  localparam int NUM_STIM = 16;

  // Directed table: 3x3 frames run back to back so the frame wrap is exercised;
  // frame rows on large grids only send the opening slice
  stim_row_t stim_tab [NUM_STIM] = '{
    // rows only: columns stay at their reset width, start of a 3x1024 frame
    '{ROW_WRITE, REG_GRID_ROWS, 11'd2,     0, 9'h000, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    '{ROW_FRAME, REG_GRID_ROWS, 11'd0,     0, 9'h000, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    // writes to unused indexes
    '{ROW_WRITE, REG_SPARE_A,   11'h7FF,   0, 9'h000, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_SPARE_B,   11'h000,   0, 9'h000, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    // 3x3: fully alive centre dies of overcrowding, then birth on three
    '{ROW_WRITE, REG_GRID_COLS, 11'd1,     0, 9'h000, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    '{ROW_CELLS, REG_GRID_ROWS, 11'd0,     9, 9'h1FF, 1'b1, 10'd1, 10'd1, 1'b0, 1'b1},
    '{ROW_CELLS, REG_GRID_ROWS, 11'd0,     9, 9'h007, 1'b1, 10'd1, 10'd1, 1'b1, 1'b1},
    // survival on two, split by an ignored write that must not restart
    '{ROW_CELLS, REG_GRID_ROWS, 11'd0,     4, 9'h001, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_SPARE_A,   11'h555,   0, 9'h000, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    '{ROW_CELLS, REG_GRID_ROWS, 11'd0,     5, 9'h011, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    // tallest grid, clamped from both ends
    '{ROW_WRITE, REG_GRID_ROWS, 11'h7FF,   0, 9'h000, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_GRID_COLS, 11'd0,     0, 9'h000, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    '{ROW_FRAME, REG_GRID_ROWS, 11'd0,     0, 9'h000, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    // widest grid, clamped from both ends
    '{ROW_WRITE, REG_GRID_COLS, 11'h7FF,   0, 9'h000, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_GRID_ROWS, 11'd1,     0, 9'h000, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0},
    '{ROW_FRAME, REG_GRID_ROWS, 11'd0,     0, 9'h000, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  cell_alive_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [OUT_POS_W-1:0]  out_row_o;
  logic [OUT_POS_W-1:0]  out_col_o;
  logic                  next_alive_o;
  logic                  frame_last_o;

  // Model state: geometry registers, line buffers, window, raster position
  logic [CFG_DATA_W-1:0] rows_reg;
  logic [CFG_DATA_W-1:0] cols_reg;
  logic                  line_above_m     [GRID_MAX_COLS];
  logic                  line_two_above_m [GRID_MAX_COLS];
  logic [5:0]            window_m;
  int unsigned           row_m;
  int unsigned           col_m;

  life_result_t next_gen_q [$];
  bit           no_gaps;
  int           n_errors;
  int           n_checked;
  int           n_cells;
  int           n_writes;
  int           n_predicted;

  life_generation_stencil_unit #(
    .MAX_ROWS (GRID_MAX_ROWS),
    .MAX_COLS (GRID_MAX_COLS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cell_alive_i (cell_alive_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .next_alive_o (next_alive_o),
    .frame_last_o (frame_last_o)
  );

  // 100 MHz clock
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic int unsigned count3(input logic [2:0] v);
    return int'(v[0]) + int'(v[1]) + int'(v[2]);
  endfunction

  // Take one cell into the model; returns 1 when an interior cell completes
  function automatic bit advance_life_cell(input logic alive, output life_result_t res);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    int unsigned total;
    logic        mid;
    logic        top;
    logic [2:0]  fresh;
    logic [2:0]  left;
    logic [2:0]  centre;
    bit          emitted;
    rows    = clamp_dim(rows_reg, GRID_MAX_ROWS);
    cols    = clamp_dim(cols_reg, GRID_MAX_COLS);
    r       = row_m;
    c       = col_m;
    emitted = 1'b0;
    res     = '0;
    if (r >= rows || c >= cols) begin
      r = 0;
      c = 0;
    end
    // shift the column of line buffers down by one row
    mid = line_above_m[c];
    top = line_two_above_m[c];
    line_two_above_m[c] = mid;
    line_above_m[c]     = alive;
    fresh = {alive, mid, top};
    if (r >= 2 && c >= 2) begin
      left   = window_m[5:3];
      centre = window_m[2:0];
      total  = count3(left) + count3(fresh) + int'(centre[0]) + int'(centre[2]);
      res.row  = OUT_POS_W'(r - 1);
      res.col  = OUT_POS_W'(c - 1);
      res.next = (total == 3) || (centre[1] && total == 2);
      res.last = (r == rows - 1) && (c == cols - 1);
      emitted  = 1'b1;
    end
    window_m = {window_m[2:0], fresh};
    // raster position, wrapping at the end of the frame
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    row_m = r;
    col_m = c;
    return emitted;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_dim();
    case ($urandom_range(0, 9))
      0:       return CFG_DATA_W'($urandom_range(0, 2));
      1:       return CFG_DATA_W'($urandom_range(11, 2047));
      default: return CFG_DATA_W'($urandom_range(3, 9));
    endcase
  endfunction

  // One cell transfer; valid is only dropped when a gap is drawn
  task automatic send_cell(input logic alive, input bit typed, input life_result_t typed_res);
    int           gap;
    bit           produced;
    life_result_t res;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cell_alive_i <= alive;
    do @(posedge clk_i); while (!in_ready_o);
    n_cells++;
    produced = advance_life_cell(alive, res);
    if (produced) begin
      next_gen_q.push_back(typed ? typed_res : res);
      n_predicted++;
    end
  endtask

  // Stop the cell stream and let every outstanding result drain
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (next_gen_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_writes++;
    // a geometry write restarts the frame; buffers and window are kept
    if (idx == REG_GRID_ROWS) begin
      rows_reg = data;
      row_m    = 0;
      col_m    = 0;
    end else if (idx == REG_GRID_COLS) begin
      cols_reg = data;
      row_m    = 0;
      col_m    = 0;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [OUT_POS_W-1:0] want,
                             input logic [OUT_POS_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Result side: random stalls, calm stretches and one long hold-off
  initial begin : result_sink
    int           stall;
    bit           calm;
    life_result_t want;
    life_result_t got;
    out_ready_i = 1'b0;
    calm        = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (n_checked % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 3);
      if (n_checked == HOLD_AT) stall = LONG_HOLD;
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = {out_row_o, out_col_o, next_alive_o, frame_last_o};
      if (next_gen_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual row %0d col %0d next %0b last %0b",
                 $time, got.row, got.col, got.next, got.last);
        n_errors++;
      end else begin
        want = next_gen_q.pop_front();
        n_checked++;
        check_field("out_row",    want.row,  got.row);
        check_field("out_col",    want.col,  got.col);
        check_field("next_alive", OUT_POS_W'(want.next), OUT_POS_W'(got.next));
        check_field("frame_last", OUT_POS_W'(want.last), OUT_POS_W'(got.last));
      end
    end
  end

  // Watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("%0t: timeout with %0d results outstanding", $time, next_gen_q.size());
    $display("FAIL");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int           frame_cells;
    int           n;
    int           spare_at;
    int           density;
    int           rand_cells;
    int           pred_base;
    life_result_t typed_res;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_GRID_ROWS;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    cell_alive_i = 1'b0;
    no_gaps      = 1'b0;
    rows_reg     = CFG_DATA_W'(CFG_DIM_RST);
    cols_reg     = CFG_DATA_W'(CFG_DIM_RST);
    window_m     = '0;
    row_m        = 0;
    col_m        = 0;
    for (int k = 0; k < GRID_MAX_COLS; k++) begin
      line_above_m[k]     = 1'b0;
      line_two_above_m[k] = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int i = 0; i < NUM_STIM; i++) begin
      case (stim_tab[i].kind)
        ROW_WRITE: write_reg(stim_tab[i].idx, stim_tab[i].data);
        ROW_CELLS: begin
          typed_res = {stim_tab[i].exp_row, stim_tab[i].exp_col,
                       stim_tab[i].exp_next, stim_tab[i].exp_last};
          for (int k = 0; k < stim_tab[i].ncells; k++)
            send_cell(stim_tab[i].pattern[k], stim_tab[i].typed, typed_res);
        end
        default: begin
          frame_cells = clamp_dim(rows_reg, GRID_MAX_ROWS) * clamp_dim(cols_reg, GRID_MAX_COLS);
          if (frame_cells > SLICE_CELLS) frame_cells = SLICE_CELLS;
          for (int k = 0; k < frame_cells; k++) send_cell(1'($urandom_range(0, 1)), 1'b0, '0);
        end
      endcase
    end

    // random shapes, densities and idling
    rand_cells = 0;
    pred_base  = n_predicted;
    while (rand_cells < RAND_CELLS || n_predicted - pred_base < RAND_RESULTS) begin
      case ($urandom_range(0, 3))
        0: write_reg(REG_GRID_ROWS, draw_dim());
        1: write_reg(REG_GRID_COLS, draw_dim());
        2: begin
          write_reg(REG_GRID_ROWS, draw_dim());
          write_reg(REG_GRID_COLS, draw_dim());
        end
        default: begin
          write_reg(REG_GRID_COLS, draw_dim());
          write_reg(REG_GRID_ROWS, draw_dim());
        end
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0:       density = 10;
        1:       density = 35;
        2:       density = 50;
        default: density = 80;
      endcase
      // small grids run whole frames plus a stub; big ones only a slice
      frame_cells = clamp_dim(rows_reg, GRID_MAX_ROWS) * clamp_dim(cols_reg, GRID_MAX_COLS);
      if (frame_cells <= 120)
        n = $urandom_range(1, 3) * frame_cells + $urandom_range(0, frame_cells - 1);
      else
        n = $urandom_range(20, 100);
      spare_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n - 1) : -1;
      for (int k = 0; k < n; k++) begin
        if (k == spare_at)
          write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                    CFG_DATA_W'($urandom_range(0, 2047)));
        send_cell($urandom_range(0, 99) < density, 1'b0, '0);
      end
      rand_cells += n;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Checked %0d next-state results from %0d cell transfers and %0d register writes,",
             n_checked, n_cells, n_writes);
    $display("over hand-made 3x3 frames, slices of 3x1024 and 1024x3 grids, random shapes.");
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
